// ===== rtl/core/fpds_pkg.sv =====
// ----------------------------------------------------------------------------
// fpds_pkg
// Shared types and constants for the farthest point double sweep block.
// ----------------------------------------------------------------------------
package fpds_pkg;

	localparam int MAX_POINTS = 16;
	localparam int COORD_W    = 13;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);
	localparam int SQ_W       = 2 * COORD_W;
	localparam int DIST_W     = SQ_W + 1;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} point_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_REF_RD,
		ST_REF_CAP,
		ST_SWEEP1,
		ST_SWEEP2,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic in_rdy;
		logic issue;
		logic load_res;
	} ctl_t;

endpackage

// ===== rtl/core/fpds_point_if.sv =====
// ----------------------------------------------------------------------------
// fpds_point_if
// Input channel: one point word per handshake, with a last flag.
// ----------------------------------------------------------------------------
interface fpds_point_if;

	logic                         valid;
	logic                         ready;
	logic [fpds_pkg::COORD_W-1:0] point_x;
	logic [fpds_pkg::COORD_W-1:0] point_y;
	logic                         last_point;

	modport source (output valid, output point_x, output point_y, output last_point,
		input ready);
	modport sink (input valid, input point_x, input point_y, input last_point,
		output ready);

endinterface

// ===== rtl/core/fpds_result_if.sv =====
// ----------------------------------------------------------------------------
// fpds_result_if
// Output channel: the two diameter end points and the overflow flag.
// ----------------------------------------------------------------------------
interface fpds_result_if;

	logic                         valid;
	logic                         ready;
	logic [fpds_pkg::COORD_W-1:0] end1_x;
	logic [fpds_pkg::COORD_W-1:0] end1_y;
	logic [fpds_pkg::COORD_W-1:0] end2_x;
	logic [fpds_pkg::COORD_W-1:0] end2_y;
	logic                         overflow;

	modport source (output valid, output end1_x, output end1_y, output end2_x,
		output end2_y, output overflow, input ready);
	modport sink (input valid, input end1_x, input end1_y, input end2_x,
		input end2_y, input overflow, output ready);

endinterface

// ===== rtl/core/fpds_ram.sv =====
// ----------------------------------------------------------------------------
// fpds_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fpds_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/farthest_point_double_sweep_top.sv =====
// ----------------------------------------------------------------------------
// farthest_point_double_sweep_top
// Stores a set of points and, after the last one, finds an approximate
// diameter by two farthest-point sweeps over the point store.
// ----------------------------------------------------------------------------
//
//  channel | dir | word                                  | handshake
//  --------+-----+---------------------------------------+-------------
//  pt      | in  | point_x, point_y, last_point          | valid/ready
//  res     | out | end1_x, end1_y, end2_x, end2_y, overflow | valid/ready
//
//  Points load into the point store at one word per cycle in ST_LOAD.
//  The last word starts the sweeps: ST_REF_RD and ST_REF_CAP fetch the
//  first point, then two passes run over the N stored points (one read a
//  cycle, three stages of distance logic, each pass ending once drained),
//  then ST_RESULT loads the result register once it is free or being read.
//  A result waiting in the output register blocks only the next set's end.
//  Reset clears the fill count, overflow flag and control; the store is left.
// ----------------------------------------------------------------------------
module farthest_point_double_sweep_top (
	input  logic               clk,
	input  logic               arst_n,
	fpds_point_if.sink         pt,
	fpds_result_if.source      res
);

	fpds_pkg::state_t state_q, state_nxt;
	fpds_pkg::ctl_t   ctl;

	logic [fpds_pkg::CNT_W-1:0] cnt_q;
	logic [fpds_pkg::CNT_W-1:0] iss_q;
	logic                       drop_q;
	logic                       accept;
	logic                       store_we;
	logic                       sweep_done;
	logic [fpds_pkg::IDX_W-1:0] raddr;
	fpds_pkg::point_t           wdata;
	fpds_pkg::point_t           rdata;

	fpds_pkg::point_t           first_q;
	fpds_pkg::point_t           ref_q;
	fpds_pkg::point_t           end1_q;
	fpds_pkg::point_t           best_q;
	logic [fpds_pkg::DIST_W-1:0] best_d_q;

	logic                         v_s1, v_s2, v_s3;
	logic [fpds_pkg::COORD_W-1:0] dx_s2, dy_s2;
	fpds_pkg::point_t             pt_s2, pt_s3;
	logic [fpds_pkg::DIST_W-1:0]  dist_s3;
	logic [fpds_pkg::SQ_W-1:0]    sqx, sqy;

	logic                         res_vld_q;
	fpds_pkg::point_t             res_e1_q, res_e2_q;
	logic                         res_ovf_q;

	assign accept     = pt.valid && ctl.in_rdy;
	assign store_we   = accept && (cnt_q < fpds_pkg::CNT_W'(fpds_pkg::MAX_POINTS));
	assign wdata      = '{x: pt.point_x, y: pt.point_y};
	assign raddr      = (state_q == fpds_pkg::ST_REF_RD) ? '0 : iss_q[fpds_pkg::IDX_W-1:0];
	assign sweep_done = (iss_q == cnt_q) && !v_s1 && !v_s2 && !v_s3;

	fpds_ram #(
		.WIDTH ($bits(fpds_pkg::point_t)),
		.DEPTH (fpds_pkg::MAX_POINTS)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (cnt_q[fpds_pkg::IDX_W-1:0]),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			fpds_pkg::ST_LOAD: begin
				if (accept && pt.last_point) begin
					state_nxt = fpds_pkg::ST_REF_RD;
				end
			end
			fpds_pkg::ST_REF_RD:  state_nxt = fpds_pkg::ST_REF_CAP;
			fpds_pkg::ST_REF_CAP: state_nxt = fpds_pkg::ST_SWEEP1;
			fpds_pkg::ST_SWEEP1: begin
				if (sweep_done) begin
					state_nxt = fpds_pkg::ST_SWEEP2;
				end
			end
			fpds_pkg::ST_SWEEP2: begin
				if (sweep_done) begin
					state_nxt = fpds_pkg::ST_RESULT;
				end
			end
			fpds_pkg::ST_RESULT: begin
				if (ctl.load_res) begin
					state_nxt = fpds_pkg::ST_LOAD;
				end
			end
			default: state_nxt = fpds_pkg::ST_LOAD;
		endcase
	end

	// outputs
	always_comb begin
		ctl = '0;
		unique case (state_q)
			fpds_pkg::ST_LOAD:   ctl.in_rdy = 1'b1;
			fpds_pkg::ST_SWEEP1,
			fpds_pkg::ST_SWEEP2: ctl.issue = (iss_q < cnt_q);
			fpds_pkg::ST_RESULT: ctl.load_res = !res_vld_q || res.ready;
			default: ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fpds_pkg::ST_LOAD;
		end else begin
			state_q <= state_nxt;
		end
	end

	// fill count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (ctl.load_res) begin
			cnt_q  <= '0;
			drop_q <= 1'b0;
		end else if (accept) begin
			if (store_we) begin
				cnt_q <= cnt_q + 1'b1;
			end else begin
				drop_q <= 1'b1;
			end
		end
	end

	// read issue and pipeline valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
		end else begin
			v_s1 <= ctl.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			if (state_q == fpds_pkg::ST_REF_CAP ||
			    (state_q == fpds_pkg::ST_SWEEP1 && sweep_done)) begin
				iss_q <= '0;
			end else if (ctl.issue) begin
				iss_q <= iss_q + 1'b1;
			end
		end
	end

	assign sqx = dx_s2 * dx_s2;
	assign sqy = dy_s2 * dy_s2;

	// distance pipeline
	always_ff @(posedge clk) begin
		if (v_s1) begin
			dx_s2 <= (rdata.x > ref_q.x) ? rdata.x - ref_q.x : ref_q.x - rdata.x;
			dy_s2 <= (rdata.y > ref_q.y) ? rdata.y - ref_q.y : ref_q.y - rdata.y;
			pt_s2 <= rdata;
		end
		if (v_s2) begin
			dist_s3 <= fpds_pkg::DIST_W'(sqx) + fpds_pkg::DIST_W'(sqy);
			pt_s3   <= pt_s2;
		end
	end

	// reference and best candidate
	always_ff @(posedge clk) begin
		if (state_q == fpds_pkg::ST_REF_CAP) begin
			first_q  <= rdata;
			ref_q    <= rdata;
			best_q   <= rdata;
			best_d_q <= '0;
		end else if (state_q == fpds_pkg::ST_SWEEP1 && sweep_done) begin
			ref_q    <= best_q;
			end1_q   <= best_q;
			best_q   <= first_q;
			best_d_q <= '0;
		end else if (v_s3 && dist_s3 > best_d_q) begin
			best_q   <= pt_s3;
			best_d_q <= dist_s3;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (ctl.load_res) begin
			res_vld_q <= 1'b1;
		end else if (res.ready) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_res) begin
			res_e1_q  <= end1_q;
			res_e2_q  <= best_q;
			res_ovf_q <= drop_q;
		end
	end

	assign pt.ready     = ctl.in_rdy;
	assign res.valid    = res_vld_q;
	assign res.end1_x   = res_e1_q.x;
	assign res.end1_y   = res_e1_q.y;
	assign res.end2_x   = res_e2_q.x;
	assign res.end2_y   = res_e2_q.y;
	assign res.overflow = res_ovf_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= fpds_pkg::CNT_W'(fpds_pkg::MAX_POINTS))
		else $error("fill count beyond store depth");

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fpds_pkg::ST_LOAD |-> !v_s1 && !v_s2 && !v_s3)
		else $error("distance pipeline busy while loading");

	a_res_from_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_res |-> $past(state_q) == fpds_pkg::ST_SWEEP2 ||
			$past(state_q) == fpds_pkg::ST_RESULT)
		else $error("result loaded without a finished second sweep");

	a_set_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == fpds_pkg::ST_REF_RD |-> cnt_q != '0)
		else $error("sweep started on an empty set");

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Drives point sets into farthest_point_double_sweep_top and checks every
// diameter result against a predictor of the two farthest-point sweeps.
// Covers single points, equal points, ties, full and overrun stores, random
// idling on both channels and one long stall of the result channel.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [fpds_pkg::COORD_W-1:0] COORD_MAX = '1;
	localparam int RANDOM_WORDS = 950;
	localparam int CALM_WORDS  = 100;
	localparam int HOLD_CYCLES = 300;
	localparam int HOLD_AFTER  = 300;
	localparam int SETTLE      = 2 * (2 + 2 * (fpds_pkg::MAX_POINTS + 3));

	typedef struct packed {
		fpds_pkg::point_t end1;
		fpds_pkg::point_t end2;
		logic             overflow;
	} ends_t;

	typedef enum int {
		MIX_RANDOM,
		MIX_CLUSTER,
		MIX_CORNERS,
		MIX_SAME
	} mix_t;

	class diameter_tracker;
		fpds_pkg::point_t held[fpds_pkg::MAX_POINTS];
		int unsigned fill;
		bit          dropped;
		ends_t       pending_ends[$];
		int unsigned n_err;
		int unsigned n_sets;
		int unsigned n_overrun_sets;
		int unsigned n_words;

		function longint unsigned sq_dist(fpds_pkg::point_t a, fpds_pkg::point_t b);
			longint unsigned dx, dy;
			dx = (a.x > b.x) ? longint'(a.x) - longint'(b.x) : longint'(b.x) - longint'(a.x);
			dy = (a.y > b.y) ? longint'(a.y) - longint'(b.y) : longint'(b.y) - longint'(a.y);
			return dx * dx + dy * dy;
		endfunction

		function int unsigned farthest_from(fpds_pkg::point_t origin);
			int unsigned     best;
			longint unsigned best_d, d;
			best = 0;
			best_d = 0;
			for (int unsigned i = 0; i < fill; i++) begin
				d = sq_dist(held[i], origin);
				if (d > best_d) begin
					best_d = d;
					best = i;
				end
			end
			return best;
		endfunction

		function void take_point(fpds_pkg::point_t p, logic last);
			ends_t       e;
			int unsigned i1, i2;
			n_words++;
			if (fill < fpds_pkg::MAX_POINTS) begin
				held[fill] = p;
				fill++;
			end else begin
				dropped = 1'b1;
			end
			if (last) begin
				i1 = farthest_from(held[0]);
				i2 = farthest_from(held[i1]);
				e.end1 = held[i1];
				e.end2 = held[i2];
				e.overflow = dropped;
				pending_ends.push_back(e);
				n_sets++;
				if (dropped)
					n_overrun_sets++;
				fill = 0;
				dropped = 1'b0;
			end
		endfunction

		task report(string what, int got, int want);
			if (n_err < 20)
				$display("mismatch %s at %0t: got %0d, expected %0d", what, $time, got, want);
			n_err++;
		endtask

		task check_ends(ends_t got);
			ends_t want;
			if (pending_ends.size() == 0) begin
				report("result with none pending", int'(got.end1.x), 0);
				return;
			end
			want = pending_ends.pop_front();
			if (got.end1.x !== want.end1.x)
				report("end1_x", int'(got.end1.x), int'(want.end1.x));
			if (got.end1.y !== want.end1.y)
				report("end1_y", int'(got.end1.y), int'(want.end1.y));
			if (got.end2.x !== want.end2.x)
				report("end2_x", int'(got.end2.x), int'(want.end2.x));
			if (got.end2.y !== want.end2.y)
				report("end2_y", int'(got.end2.y), int'(want.end2.y));
			if (got.overflow !== want.overflow)
				report("overflow", int'(got.overflow), int'(want.overflow));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;

	fpds_point_if  pt_ch();
	fpds_result_if res_ch();

	farthest_point_double_sweep_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pt     (pt_ch),
		.res    (res_ch)
	);

	diameter_tracker tracker = new;

	int unsigned n_sent;
	int unsigned tx_rate;
	int unsigned rx_rate;
	int unsigned rx_idle;
	bit          calm;
	logic        long_hold;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	task automatic send_point(input fpds_pkg::point_t p, input logic last);
		if (!calm && tx_rate > 0 && $urandom_range(0, 7) < tx_rate) begin
			pt_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		pt_ch.valid      <= 1'b1;
		pt_ch.point_x    <= p.x;
		pt_ch.point_y    <= p.y;
		pt_ch.last_point <= last;
		@(posedge clk);
		while (!pt_ch.ready)
			@(posedge clk);
		tracker.take_point(p, last);
		n_sent++;
		if (n_sent + CALM_WORDS >= RANDOM_WORDS)
			calm = 1'b1;
	endtask

	function automatic logic [fpds_pkg::COORD_W-1:0] corner_coord();
		case ($urandom_range(0, 2))
			0: return '0;
			1: return COORD_MAX;
			default: return fpds_pkg::COORD_W'($urandom_range(0, COORD_MAX));
		endcase
	endfunction

	task automatic send_random_set();
		int unsigned      n, r;
		mix_t             mix;
		fpds_pkg::point_t p, base;
		r = $urandom_range(0, 19);
		if (r < 2)
			n = fpds_pkg::MAX_POINTS;
		else if (r < 5)
			n = $urandom_range(fpds_pkg::MAX_POINTS + 1, fpds_pkg::MAX_POINTS + 6);
		else
			n = $urandom_range(1, fpds_pkg::MAX_POINTS - 1);
		mix = mix_t'($urandom_range(MIX_RANDOM, MIX_SAME));
		tx_rate = $urandom_range(0, 3);
		base.x = fpds_pkg::COORD_W'($urandom_range(0, COORD_MAX - 3));
		base.y = fpds_pkg::COORD_W'($urandom_range(0, COORD_MAX - 3));
		for (int unsigned k = 0; k < n; k++) begin
			case (mix)
				MIX_CLUSTER: begin
					p.x = base.x + fpds_pkg::COORD_W'($urandom_range(0, 3));
					p.y = base.y + fpds_pkg::COORD_W'($urandom_range(0, 3));
				end
				MIX_CORNERS: begin
					p.x = corner_coord();
					p.y = corner_coord();
				end
				MIX_SAME: p = base;
				default: begin
					p.x = fpds_pkg::COORD_W'($urandom_range(0, COORD_MAX));
					p.y = fpds_pkg::COORD_W'($urandom_range(0, COORD_MAX));
				end
			endcase
			send_point(p, k == n - 1);
		end
	endtask

	initial begin
		arst_n           = 1'b0;
		pt_ch.valid      = 1'b0;
		pt_ch.point_x    = '0;
		pt_ch.point_y    = '0;
		pt_ch.last_point = 1'b0;
		n_sent           = 0;
		tx_rate          = 0;
		calm             = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// lone points at opposite corners
		send_point('{x: COORD_MAX, y: '0}, 1'b1);
		send_point('{x: '0, y: COORD_MAX}, 1'b1);
		// diagonal pair
		send_point('{x: '0, y: '0}, 1'b0);
		send_point('{x: COORD_MAX, y: COORD_MAX}, 1'b1);
		// equal points keep the first
		send_point('{x: 13'h1555, y: 13'h0aaa}, 1'b0);
		send_point('{x: 13'h1555, y: 13'h0aaa}, 1'b0);
		send_point('{x: 13'h1555, y: 13'h0aaa}, 1'b1);
		// equal distances keep the earlier point
		send_point('{x: 13'd100, y: 13'd100}, 1'b0);
		send_point('{x: 13'd110, y: 13'd100}, 1'b0);
		send_point('{x: 13'd90, y: 13'd100}, 1'b0);
		send_point('{x: 13'd100, y: 13'd110}, 1'b1);

		tx_rate = 2;
		while (n_sent < RANDOM_WORDS)
			send_random_set();
		pt_ch.valid <= 1'b0;

		while (tracker.pending_ends.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);

		$display("covered %0d point words in %0d sets, %0d of them overran the store",
			tracker.n_words, tracker.n_sets, tracker.n_overrun_sets);
		$display("result channel stalled for %0d cycles once to back up the input",
			HOLD_CYCLES);
		if (tracker.n_err == 0 && tracker.pending_ends.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		res_ch.ready = 1'b0;
		rx_idle      = 0;
		rx_rate      = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				tracker.check_ends('{end1: '{x: res_ch.end1_x, y: res_ch.end1_y},
					end2: '{x: res_ch.end2_x, y: res_ch.end2_y},
					overflow: res_ch.overflow});
			if ($urandom_range(0, 49) == 0)
				rx_rate = $urandom_range(0, 3);
			if (long_hold) begin
				res_ch.ready <= 1'b0;
			end else if (rx_idle > 0) begin
				rx_idle--;
				res_ch.ready <= 1'b0;
			end else if (!calm && rx_rate > 0 && $urandom_range(0, 7) < rx_rate) begin
				rx_idle = $urandom_range(1, 7) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	initial begin
		long_hold = 1'b0;
		wait (n_sent >= HOLD_AFTER);
		@(posedge clk);
		long_hold <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		long_hold <= 1'b0;
	end

	initial begin
		#800000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
